[hw/rtl/window_peak_detector_defines.svh]
// Assertion macros used by the window peak detector top level
`ifndef WINDOW_PEAK_DETECTOR_DEFINES_SVH
`define WINDOW_PEAK_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define WPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define WPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/wpd_pkg.sv]
// Shared types and constants of the window peak detector
`timescale 1ns / 1ps
package wpd_pkg;

	localparam int HW_REG_BITS     = 7;
	localparam int THRESH_BITS     = 24;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 24;
	localparam int MIN_RECORD      = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_WINDOW = 2'd1;

	typedef struct packed {
		logic                   shift;
		logic [HW_REG_BITS-1:0] hw;
	} wpd_cell_ctrl_t;

endpackage

[hw/rtl/wpd_cell.sv]
// One history cell: holds a sample, compares it against the window centre
`timescale 1ns / 1ps
module wpd_cell #(
	parameter int SAMPLE_BITS = 24,
	parameter int POS         = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wpd_pkg::wpd_cell_ctrl_t       ctrl,
	input  logic signed [SAMPLE_BITS-1:0] d_in,
	input  logic signed [SAMPLE_BITS-1:0] centre,
	output logic signed [SAMPLE_BITS-1:0] q,
	output logic                          gt,
	output logic        [SAMPLE_BITS-1:0] pick
);
	import wpd_pkg::*;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          gt_q;
	logic                          in_win;
	logic                          sel;

	assign in_win = (32'(POS) <= 32'({ctrl.hw, 1'b0}));
	assign sel    = (32'(POS) == 32'(ctrl.hw));
	assign pick   = sel ? d_in : '0;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			sample_q <= d_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gt_q <= 1'b0;
		end else if (ctrl.shift) begin
			gt_q <= in_win && (d_in > centre);
		end
	end

	assign q  = sample_q;
	assign gt = gt_q;

endmodule

[hw/rtl/window_peak_detector.sv]
// Top level of the window peak detector: cell chain, decision stage, output word
//
// channel  direction  handshake              payload
// in       in         in_valid / in_stall    sample, last_in_record
// out      out        out_valid / out_stall  peak_index, peak_value, short_record
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample per cycle unless in_stall; results pass stage s1, then the output word.
// The history is a chain of 2*MAX_HALF_WINDOW+1 cells that compare in parallel.
// arst_n clears position, valid and gt flags and threshold; samples are not cleared.
// in_stall rises only when the decision stage is full and the output word is stalled.
`timescale 1ns / 1ps
module window_peak_detector #(
	parameter int MAX_HALF_WINDOW = 64,
	parameter int SAMPLE_BITS     = 24,
	parameter int INDEX_BITS      = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	input  logic                                last_in_record,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic        [INDEX_BITS-1:0]        peak_index,
	output logic signed [SAMPLE_BITS-1:0]       peak_value,
	output logic                                short_record,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wpd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [wpd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import wpd_pkg::*;

	localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;

	logic signed [THRESH_BITS-1:0] threshold_q;
	logic [HW_REG_BITS-1:0]        half_window_q;
	logic [HW_REG_BITS-1:0]        hw_eff;
	logic [INDEX_BITS-1:0]         pos_q;

	logic                          accept;
	logic                          out_free;
	logic                          hit;
	wpd_cell_ctrl_t                cell_ctrl;

	logic signed [SAMPLE_BITS-1:0] hist [DEPTH];
	logic        [SAMPLE_BITS-1:0] pick [DEPTH];
	logic        [DEPTH-1:0]       gt;
	logic        [SAMPLE_BITS-1:0] pick_or;
	logic signed [SAMPLE_BITS-1:0] centre;

	logic                          v_s1;
	logic                          short_s1;
	logic                          pos_ok_s1;
	logic                          above_s1;
	logic        [INDEX_BITS-1:0]  index_s1;
	logic signed [SAMPLE_BITS-1:0] value_s1;

	logic                          out_valid_q;
	logic        [INDEX_BITS-1:0]  peak_index_q;
	logic signed [SAMPLE_BITS-1:0] peak_value_q;
	logic                          short_record_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= '0;
			half_window_q <= HW_REG_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD:   threshold_q   <= signed'(cfg_data[THRESH_BITS-1:0]);
				REG_HALF_WINDOW: half_window_q <= cfg_data[HW_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (half_window_q == '0) begin
			hw_eff = HW_REG_BITS'(1);
		end else if (32'(half_window_q) > 32'(MAX_HALF_WINDOW)) begin
			hw_eff = HW_REG_BITS'(MAX_HALF_WINDOW);
		end else begin
			hw_eff = half_window_q;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = v_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	assign cell_ctrl.shift = accept;
	assign cell_ctrl.hw    = hw_eff;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] d_in;
		if (k == 0) begin : g_head
			assign d_in = sample;
		end else begin : g_link
			assign d_in = hist[k-1];
		end
		wpd_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.POS         (k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (cell_ctrl),
			.d_in   (d_in),
			.centre (centre),
			.q      (hist[k]),
			.gt     (gt[k]),
			.pick   (pick[k])
		);
	end

	always_comb begin
		pick_or = '0;
		for (int k = 0; k < DEPTH; k++) begin
			pick_or = pick_or | pick[k];
		end
	end

	assign centre = signed'(pick_or);

	// advance the record position, restart at the record end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (last_in_record) begin
				pos_q <= '0;
			end else if (pos_q != '1) begin
				pos_q <= pos_q + INDEX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (out_free) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			short_s1  <= last_in_record && (32'(pos_q) < 32'(MIN_RECORD - 1));
			pos_ok_s1 <= pos_q >= INDEX_BITS'({hw_eff, 1'b0});
			above_s1  <= centre > threshold_q;
			index_s1  <= pos_q - INDEX_BITS'(hw_eff);
			value_s1  <= centre;
		end
	end

	assign hit = v_s1 && (short_s1 || (pos_ok_s1 && above_s1 && !(|gt)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && hit) begin
			short_record_q <= short_s1;
			peak_index_q   <= short_s1 ? '0 : index_s1;
			peak_value_q   <= short_s1 ? '0 : value_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign peak_index   = peak_index_q;
	assign peak_value   = peak_value_q;
	assign short_record = short_record_q;

`include "window_peak_detector_defines.svh"

	`WPD_ASSERT_NOW(a_stall_only_when_full, in_stall, v_s1 && out_valid && out_stall, "input stalled with room downstream")
	`WPD_ASSERT_NOW(a_short_word_zero, out_valid && short_record, peak_index == '0 && peak_value == '0, "short record word carries data")
	`WPD_ASSERT_NEXT(a_restart_on_last, accept && last_in_record, pos_q == '0, "position not cleared at record end")
	`WPD_ASSERT_NEXT(a_stage_filled, accept, v_s1, "accepted word lost before decision")
	`WPD_ASSERT_NEXT(a_position_moves, accept && !last_in_record, pos_q != '0, "position did not advance")

endmodule

[dv/window_peak_detector_test.sv]
// Self-checking testbench for the window peak detector: random records, window and threshold sweeps
`timescale 1ns / 1ps
module window_peak_detector_test;
	import wpd_pkg::*;

	localparam int SAMPLE_W       = 24;
	localparam int INDEX_W        = 24;
	localparam int MAX_HW         = 64;
	localparam int HIST_LEN       = 2 * MAX_HW + 1;
	localparam int SETTLE         = 8;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int SQUEEZE_CYCLES = 600;

	localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

	localparam int DIR_LEN = 17;
	localparam logic signed [SAMPLE_W-1:0] DIR_SAMPLES [DIR_LEN] = '{
		24'sd5,
		S_MIN, S_MAX,
		24'sd0, S_MAX, S_MAX, S_MAX, S_MIN, 24'sd100, 24'sd50,
		24'sd0, 24'sd0, 24'sd0,
		-24'sd1, 24'sd1, -24'sd1, S_MIN
	};
	localparam bit DIR_LAST [DIR_LEN] = '{
		1'b1,
		1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1
	};

	typedef struct packed {
		logic [INDEX_W-1:0]  pos_idx;
		logic [SAMPLE_W-1:0] level;
		logic                is_short;
	} peak_word_t;

	class peak_ledger;
		logic signed [SAMPLE_W-1:0] hist [HIST_LEN];
		int                         wr_ptr;
		logic [INDEX_W-1:0]         pos;
		logic signed [SAMPLE_W-1:0] thr;
		logic [HW_REG_BITS-1:0]     hw_reg;
		peak_word_t                 due_words [$];
		int                         errors;
		int                         n_samples;
		int                         n_records;
		int                         n_peaks;
		int                         n_shorts;

		function new();
			wr_ptr    = 0;
			pos       = '0;
			thr       = '0;
			hw_reg    = HW_REG_BITS'(1);
			errors    = 0;
			n_samples = 0;
			n_records = 0;
			n_peaks   = 0;
			n_shorts  = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx == REG_THRESHOLD) begin
				thr = data[THRESH_BITS-1:0];
			end else if (idx == REG_HALF_WINDOW) begin
				hw_reg = data[HW_REG_BITS-1:0];
			end
		endfunction

		function int half_width();
			int h;
			h = hw_reg;
			if (h < 1) h = 1;
			if (h > MAX_HW) h = MAX_HW;
			return h;
		endfunction

		function int slot(int back);
			return (wr_ptr + HIST_LEN - back) % HIST_LEN;
		endfunction

		function void queue_word(peak_word_t w);
			due_words.insert(due_words.size(), w);
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] s, logic last);
			int                         h;
			logic signed [SAMPLE_W-1:0] centre;
			bit                         is_max;
			peak_word_t                 w;
			h = half_width();
			n_samples++;
			wr_ptr = (wr_ptr + 1) % HIST_LEN;
			hist[wr_ptr] = s;
			if (pos >= 2 * h) begin
				centre = hist[slot(h)];
				is_max = 1'b1;
				for (int k = 0; k <= 2 * h; k++)
					if (hist[slot(k)] > centre) is_max = 1'b0;
				if (is_max && centre > thr) begin
					w.pos_idx  = pos - INDEX_W'(h);
					w.level    = centre;
					w.is_short = 1'b0;
					queue_word(w);
					n_peaks++;
				end
			end
			if (last) begin
				if (pos + 1 < MIN_RECORD) begin
					w.pos_idx  = '0;
					w.level    = '0;
					w.is_short = 1'b1;
					queue_word(w);
					n_shorts++;
				end
				n_records++;
				pos    = '0;
				wr_ptr = 0;
			end else if (pos != '1) begin
				pos = pos + 1'b1;
			end
		endfunction

		function void match_word(logic [INDEX_W-1:0] idx, logic signed [SAMPLE_W-1:0] lvl,
				logic sh);
			peak_word_t w;
			if (due_words.size() == 0) begin
				errors++;
				$display("%0t: expected no word, actual index %0d value %0d short_record %0b",
					$time, idx, lvl, sh);
				return;
			end
			w = due_words.pop_front();
			if (idx !== w.pos_idx) begin
				errors++;
				$display("%0t: peak_index expected %0d actual %0d", $time, w.pos_idx, idx);
			end
			if (lvl !== w.level) begin
				errors++;
				$display("%0t: peak_value expected %0d actual %0d", $time,
					$signed(w.level), lvl);
			end
			if (sh !== w.is_short) begin
				errors++;
				$display("%0t: short_record expected %0b actual %0b", $time, w.is_short, sh);
			end
		endfunction
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic signed [SAMPLE_W-1:0]         sample;
	logic                               last_in_record;
	logic                               out_valid;
	logic                               out_stall;
	logic        [INDEX_W-1:0]          peak_index;
	logic signed [SAMPLE_W-1:0]         peak_value;
	logic                               short_record;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic        [CFG_INDEX_BITS-1:0]   cfg_index;
	logic        [CFG_DATA_BITS-1:0]    cfg_data;

	peak_ledger                 ledger;
	int unsigned                cycle_count = 0;
	int                         burst_left = 0;
	int                         rec_left = 0;
	int                         rec_mode = 0;
	int                         n_settings = 0;
	logic signed [SAMPLE_W-1:0] prev_sample = '0;
	logic signed [SAMPLE_W-1:0] base_level = '0;
	bit                         squeeze_req = 1'b0;
	bit                         squeeze_done = 1'b0;

	window_peak_detector u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample        (sample),
		.last_in_record(last_in_record),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.peak_index    (peak_index),
		.peak_value    (peak_value),
		.short_record  (short_record),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout, %0d words still due", $time, ledger.due_words.size());
		$display("** window_peak_detector: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			ledger.match_word(peak_index, peak_value, short_record);
	end

	initial begin : receiver
		int mode;
		int span;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				out_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 150);
			for (int c = 0; c < span; c++) begin
				if (squeeze_req && !squeeze_done) break;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ((c % 6) < 2);
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] gen_sample(int mode,
			logic signed [SAMPLE_W-1:0] prev, logic signed [SAMPLE_W-1:0] base);
		int step;
		step = $urandom_range(0, 6);
		step = step - 3;
		case (mode)
			0: return SAMPLE_W'($urandom);
			1: return base + SAMPLE_W'($urandom_range(0, 2));
			2: begin
				case ($urandom_range(0, 3))
					0: return S_MIN;
					1: return S_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return prev + SAMPLE_W'(step);
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_level();
		if ($urandom_range(0, 3) == 0) return SAMPLE_W'($urandom);
		return SAMPLE_W'($urandom_range(0, 4000) - 2000);
	endfunction

	function automatic logic [HW_REG_BITS-1:0] rand_half();
		if ($urandom_range(0, 2) == 0) return HW_REG_BITS'($urandom_range(9, MAX_HW));
		return HW_REG_BITS'($urandom_range(1, 8));
	endfunction

	task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 250)
				: $urandom_range(1, 30);
		end
		burst_left--;
		in_valid       <= 1'b1;
		sample         <= s;
		last_in_record <= last;
		do @(posedge clk); while (in_stall);
		ledger.note_sample(s, last);
	endtask

	task automatic send_random(input int count);
		int                         h;
		int                         r;
		logic signed [SAMPLE_W-1:0] s;
		for (int i = 0; i < count; i++) begin
			if (rec_left == 0) begin
				h = ledger.half_width();
				r = $urandom_range(0, 99);
				if (r < 8) rec_left = $urandom_range(1, 2);
				else if (r < 22) rec_left = $urandom_range(3, 2 * h + 1);
				else rec_left = $urandom_range(2 * h + 1, 6 * h + 12);
				rec_mode    = $urandom_range(0, 3);
				base_level  = SAMPLE_W'($urandom);
				prev_sample = SAMPLE_W'($urandom);
			end
			s = gen_sample(rec_mode, prev_sample, base_level);
			prev_sample = s;
			send_word(s, rec_left == 1);
			rec_left--;
		end
	endtask

	task automatic wait_idle();
		while (ledger.due_words.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apply_setting(input logic signed [SAMPLE_W-1:0] thr,
			input logic [HW_REG_BITS-1:0] hw);
		logic [CFG_DATA_BITS-1:0] hw_word;
		hw_word   = {{(CFG_DATA_BITS-HW_REG_BITS){1'b0}}, hw};
		cfg_valid <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data  <= thr;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(REG_THRESHOLD, thr);
		cfg_index <= REG_HALF_WINDOW;
		cfg_data  <= hw_word;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(REG_HALF_WINDOW, hw_word);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic run_phase(input logic signed [SAMPLE_W-1:0] thr,
			input logic [HW_REG_BITS-1:0] hw, input int count);
		apply_setting(thr, hw);
		send_random(count);
		in_valid <= 1'b0;
		wait_idle();
	endtask

	initial begin : main
		ledger = new();
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		sample         <= '0;
		last_in_record <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= REG_THRESHOLD;
		cfg_data       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_LEN; i++)
			send_word(DIR_SAMPLES[i], DIR_LAST[i]);
		in_valid <= 1'b0;
		wait_idle();

		squeeze_req = 1'b1;
		run_phase(S_MIN, 7'd1, 250);
		run_phase(S_MAX, 7'd1, 120);
		run_phase('0, 7'd64, 180);
		run_phase(S_MIN, 7'd64, 180);
		run_phase(rand_level(), 7'd0, 120);
		run_phase(rand_level(), 7'd127, 120);
		repeat (4) run_phase(rand_level(), rand_half(), 120);
		run_phase('0, 7'd2, 180);

		$display("Run: %0d samples in %0d records across %0d window/threshold settings",
			ledger.n_samples, ledger.n_records, n_settings);
		$display("Run: %0d peaks and %0d short records checked, one %0d-cycle output hold-off",
			ledger.n_peaks, ledger.n_shorts, SQUEEZE_CYCLES);
		if (ledger.errors == 0) begin
			$display("** window_peak_detector: PASSED **");
		end else begin
			$display("** window_peak_detector: FAILED **");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/wpd_pkg.sv
hw/rtl/wpd_cell.sv
hw/rtl/window_peak_detector.sv
dv/window_peak_detector_test.sv
